>>> rtl/ecu_pkg.sv
package ecu_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int TABLE_POINTS = 256;
   localparam int IDX_BITS     = $clog2(TABLE_POINTS);
   localparam int LERP_BITS    = FRAC_BITS - IDX_BITS;
   localparam int T_W          = FRAC_BITS + 1;   // 0 .. 1.0
   localparam int TAB_W        = FRAC_BITS + 2;   // 0 .. 2.0
   localparam int SH_W         = 4;
   localparam int N_W          = FRAC_BITS + 4;   // up to 10.0
   localparam int TIN_W        = 18;

   localparam logic [T_W-1:0] ONE_FX  = T_W'(1) << FRAC_BITS;
   localparam logic [T_W-1:0] HALF_FX = T_W'(1) << (FRAC_BITS - 1);

   localparam longint unsigned Q30_HALFPI = 64'd1686629713;
   localparam longint unsigned Q30_LN2    = 64'd744261118;

   typedef enum logic [3:0] {
      CRV_LINEAR     = 4'd0,
      CRV_QUAD_IN    = 4'd1,
      CRV_QUAD_OUT   = 4'd2,
      CRV_QUAD_INOUT = 4'd3,
      CRV_CUBE_IN    = 4'd4,
      CRV_CUBE_OUT   = 4'd5,
      CRV_CUBE_INOUT = 4'd6,
      CRV_SINE_IN    = 4'd7,
      CRV_SINE_OUT   = 4'd8,
      CRV_SINE_INOUT = 4'd9,
      CRV_EXPO_IN    = 4'd10,
      CRV_EXPO_OUT   = 4'd11,
      CRV_EXPO_INOUT = 4'd12,
      CRV_HOLD       = 4'd13,
      CRV_PASS_A     = 4'd14,
      CRV_PASS_B     = 4'd15
   } curve_type;

   typedef logic [TAB_W-1:0] tab_type [0:TABLE_POINTS];

   function automatic longint unsigned q30_to_fx(input longint unsigned v);
      return (v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
   endfunction

   // shift-and-subtract quotient, only used while building the tables
   function automatic longint unsigned div_u(input longint unsigned num,
                                             input longint unsigned den);
      longint unsigned q, r;
      q = 0;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
         r = (r << 1) | ((num >> b) & 64'd1);
         if (r >= den) begin
            r = r - den;
            q = q | (64'd1 << b);
         end
      end
      return q;
   endfunction

   // sin(x) for x in 0..pi/2, Taylor series in Q30
   function automatic tab_type build_sine();
      tab_type tab;
      longint unsigned x, x2, term, sum;
      for (int i = 0; i <= TABLE_POINTS; i++) begin
         x    = (longint'(i) * Q30_HALFPI) / TABLE_POINTS;
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         for (int k = 1; k < 24; k++) begin
            if (term != 0) begin
               term = div_u((term * x2) >> 30, longint'((2 * k) * (2 * k + 1)));
               if (k % 2 == 1) sum = sum - term;
               else sum = sum + term;
            end
         end
         tab[i] = TAB_W'(q30_to_fx(sum));
      end
      tab[0]            = '0;
      tab[TABLE_POINTS] = TAB_W'(ONE_FX);
      return tab;
   endfunction

   // 2^f for f in 0..1, as exp(f ln2) in Q30
   function automatic tab_type build_exp2();
      tab_type tab;
      longint unsigned y, et, es;
      for (int i = 0; i <= TABLE_POINTS; i++) begin
         y  = (longint'(i) * Q30_LN2) / TABLE_POINTS;
         et = 64'd1 << 30;
         es = 64'd1 << 30;
         for (int k = 1; k < 24; k++) begin
            if (et != 0) begin
               et = div_u((et * y) >> 30, longint'(k));
               es = es + et;
            end
         end
         tab[i] = TAB_W'(q30_to_fx(es));
      end
      tab[0]            = TAB_W'(ONE_FX);
      tab[TABLE_POINTS] = TAB_W'(ONE_FX) << 1;
      return tab;
   endfunction

   localparam tab_type SINE_TAB = build_sine();
   localparam tab_type EXP2_TAB = build_exp2();

endpackage

>>> rtl/ecu_lut.sv
module ecu_lut (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [ecu_pkg::T_W-1:0]    p,
   input  logic                       use_exp,
   output logic [ecu_pkg::TAB_W-1:0]  value
);
   import ecu_pkg::*;

   localparam logic [IDX_BITS:0] LAST_IDX = (IDX_BITS+1)'(TABLE_POINTS);

   logic [IDX_BITS:0]    idx, idx_b;
   logic                 at_end_in, at_end_ff;
   logic [TAB_W-1:0]     lo_in, hi_in, lo_ff, hi_ff;
   logic [LERP_BITS-1:0] frac_ff;
   logic [TAB_W-1:0]     diff;
   logic [TAB_W+LERP_BITS-1:0] step;
   logic [TAB_W-1:0]     value_in, value_ff;

   // stage A: table reads at both neighbouring points
   always_comb begin
      idx       = p[T_W-1:LERP_BITS];
      at_end_in = (idx == LAST_IDX);
      idx_b     = at_end_in ? idx : idx + 1'b1;
      lo_in     = use_exp ? EXP2_TAB[idx]   : SINE_TAB[idx];
      hi_in     = use_exp ? EXP2_TAB[idx_b] : SINE_TAB[idx_b];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
         frac_ff   <= p[LERP_BITS-1:0];
         at_end_ff <= at_end_in;
      end
   end

   // stage B: linear interpolation, rounded
   always_comb begin
      diff     = (hi_ff >= lo_ff) ? hi_ff - lo_ff : '0;
      step     = (diff * frac_ff) + ((TAB_W+LERP_BITS)'(1) << (LERP_BITS - 1));
      value_in = at_end_ff ? lo_ff : lo_ff + TAB_W'(step >> LERP_BITS);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

>>> rtl/easing_curve_unit.sv
// Channel   | Direction | Word contents (lowest bit first)
// ----------+-----------+------------------------------------------------
// req_      | in        | tdata: t_in[17:0] signed, 6 pad; tuser: action[3:0]
// rsp_      | out       | tdata: eased[16:0], 7 pad
//
// Five register stages: clamp, operand set-up, first multiply / table read,
// second multiply / interpolation, output select. One word is taken every cycle
// while the pipe advances. All stages move together on one advance
// signal, held back only while the output register is full and not taken.
// Reset (synchronous, active high) clears the valid bits; data is not reset.
module easing_curve_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [17:0] t_in, [23:18] zero
   input  logic [3:0]  req_tuser,   // [3:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [16:0] eased, [23:17] zero
);
   import ecu_pkg::*;

   localparam logic [N_W-1:0] TEN_FX = N_W'(ONE_FX) * N_W'(10);

   logic advance;
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;

   // stage 1: clamp
   logic [TIN_W-1:0] raw;
   logic [T_W-1:0]   t1_in, t1_ff;
   curve_type        sel1_ff;

   // stage 2: operands
   curve_type        sel2_ff;
   logic [T_W-1:0]   t2_ff;
   logic             lo2_ff, le2_ff, full2_ff, zero2_ff;
   logic [T_W-1:0]   u1, a2_in, b2_in, p2_in, a2_ff, b2_ff;
   logic             exp2_in;
   logic [N_W:0]     t10, t20, n_full;
   logic [N_W-1:0]   n;
   logic             extra;
   logic [SH_W-1:0]  sh2_in, sh2_ff;
   logic [T_W-1:0]   p2_in_ff;
   logic             exp2_ff;

   // stage 3: first product
   curve_type        sel3_ff;
   logic [T_W-1:0]   t3_ff, a3_ff, m1_in, m1_ff;
   logic             lo3_ff, le3_ff, full3_ff, zero3_ff;
   logic [SH_W-1:0]  sh3_ff;
   logic [2*T_W-1:0] prod1, prod2;

   // stage 4: second product, lookup value from ecu_lut
   curve_type        sel4_ff;
   logic [T_W-1:0]   t4_ff, m1b_ff, m2_in, m2_ff;
   logic             lo4_ff, le4_ff, full4_ff, zero4_ff;
   logic [SH_W-1:0]  sh4_ff;
   logic [TAB_W-1:0] lut4;

   // stage 5: output
   logic [TAB_W:0]   pw_sum;
   logic [T_W-1:0]   pw, lut_t, half_c;
   logic [T_W:0]     sine_mid;
   logic [T_W-1:0]   eased_in, eased_ff;

   // the whole pipe moves unless a finished word is waiting and not taken
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= req_tvalid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= v4_ff;
      end
   end

   // ---- stage 1: clamp to 0 .. 1.0
   always_comb begin
      raw = req_tdata[TIN_W-1:0];
      if (raw[TIN_W-1]) begin
         t1_in = '0;
      end else if (raw[TIN_W-2:0] > (TIN_W-1)'(ONE_FX)) begin
         t1_in = ONE_FX;
      end else begin
         t1_in = raw[T_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t1_ff   <= t1_in;
         sel1_ff <= curve_type'(req_tuser);
      end
   end

   // ---- stage 2: pick multiplier operands, table point and exponent
   always_comb begin
      u1      = ONE_FX - t1_ff;
      t10     = ((N_W+1)'(t1_ff) << 3) + ((N_W+1)'(t1_ff) << 1);
      t20     = t10 << 1;
      a2_in   = t1_ff;
      b2_in   = t1_ff;
      p2_in   = t1_ff;
      exp2_in = 1'b0;
      extra   = 1'b0;
      n_full  = t10;
      case (sel1_ff)
         CRV_QUAD_OUT, CRV_CUBE_OUT: begin
            a2_in = u1;
            b2_in = u1;
         end
         CRV_QUAD_INOUT, CRV_CUBE_INOUT: begin
            if (t1_ff < HALF_FX) begin
               a2_in = t1_ff << 1;
            end else begin
               a2_in = u1 << 1;
               b2_in = u1;
            end
            // cubic squares the doubled value
            if (sel1_ff == CRV_CUBE_INOUT) b2_in = a2_in;
         end
         CRV_SINE_IN:  p2_in = u1;
         CRV_SINE_OUT: p2_in = t1_ff;
         CRV_SINE_INOUT: begin
            if (t1_ff <= HALF_FX) p2_in = ONE_FX - (t1_ff << 1);
            else p2_in = (t1_ff << 1) - ONE_FX;
         end
         CRV_EXPO_IN: begin
            exp2_in = 1'b1;
            n_full  = (N_W+1)'(TEN_FX) - t10;
         end
         CRV_EXPO_OUT: begin
            exp2_in = 1'b1;
         end
         CRV_EXPO_INOUT: begin
            exp2_in = 1'b1;
            extra   = 1'b1;
            if (t1_ff < HALF_FX) n_full = (N_W+1)'(TEN_FX) - t20;
            else n_full = t20 - (N_W+1)'(TEN_FX);
         end
         default: ;
      endcase
      n = n_full[N_W-1:0];
      if (exp2_in) p2_in = ONE_FX - T_W'(n[FRAC_BITS-1:0]);
      sh2_in = n[N_W-1:FRAC_BITS] + SH_W'(1) + SH_W'(extra);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sel2_ff  <= sel1_ff;
         t2_ff    <= t1_ff;
         lo2_ff   <= (t1_ff < HALF_FX);
         le2_ff   <= (t1_ff <= HALF_FX);
         full2_ff <= (t1_ff == ONE_FX);
         zero2_ff <= (t1_ff == '0);
         a2_ff    <= a2_in;
         b2_ff    <= b2_in;
         sh2_ff   <= sh2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p2_in_ff <= p2_in;
         exp2_ff  <= exp2_in;
      end
   end

   // table lookup runs alongside stages 3 and 4
   ecu_lut u_lut (
      .clock   (clock),
      .enable  (advance),
      .p       (p2_in_ff),
      .use_exp (exp2_ff),
      .value   (lut4)
   );

   // ---- stage 3: first rounded product
   always_comb begin
      prod1 = (a2_ff * b2_ff) + (2*T_W)'(HALF_FX);
      m1_in = prod1[FRAC_BITS+T_W-1:FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sel3_ff  <= sel2_ff;
         t3_ff    <= t2_ff;
         a3_ff    <= a2_ff;
         m1_ff    <= m1_in;
         lo3_ff   <= lo2_ff;
         le3_ff   <= le2_ff;
         full3_ff <= full2_ff;
         zero3_ff <= zero2_ff;
         sh3_ff   <= sh2_ff;
      end
   end

   // ---- stage 4: second rounded product gives the cube
   always_comb begin
      prod2 = (m1_ff * a3_ff) + (2*T_W)'(HALF_FX);
      m2_in = prod2[FRAC_BITS+T_W-1:FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sel4_ff  <= sel3_ff;
         t4_ff    <= t3_ff;
         m1b_ff   <= m1_ff;
         m2_ff    <= m2_in;
         lo4_ff   <= lo3_ff;
         le4_ff   <= le3_ff;
         full4_ff <= full3_ff;
         zero4_ff <= zero3_ff;
         sh4_ff   <= sh3_ff;
      end
   end

   // ---- stage 5: shift, halve, mirror and select
   always_comb begin
      pw_sum   = (TAB_W+1)'(lut4) + ((TAB_W+1)'(1) << (sh4_ff - SH_W'(1)));
      pw       = T_W'(pw_sum >> sh4_ff);
      lut_t    = lut4[T_W-1:0];
      half_c   = T_W'(((T_W+1)'(m2_ff) + (T_W+1)'(1)) >> 1);
      if (le4_ff) sine_mid = (T_W+1)'(ONE_FX) - (T_W+1)'(lut_t) + (T_W+1)'(1);
      else sine_mid = (T_W+1)'(ONE_FX) + (T_W+1)'(lut_t) + (T_W+1)'(1);
      case (sel4_ff)
         CRV_QUAD_IN:    eased_in = m1b_ff;
         CRV_QUAD_OUT:   eased_in = ONE_FX - m1b_ff;
         CRV_QUAD_INOUT: eased_in = lo4_ff ? m1b_ff : ONE_FX - m1b_ff;
         CRV_CUBE_IN:    eased_in = m2_ff;
         CRV_CUBE_OUT:   eased_in = ONE_FX - m2_ff;
         CRV_CUBE_INOUT: eased_in = lo4_ff ? half_c : ONE_FX - half_c;
         CRV_SINE_IN:    eased_in = ONE_FX - lut_t;
         CRV_SINE_OUT:   eased_in = lut_t;
         CRV_SINE_INOUT: eased_in = sine_mid[T_W:1];
         CRV_EXPO_IN:    eased_in = zero4_ff ? '0 : pw;
         CRV_EXPO_OUT:   eased_in = full4_ff ? ONE_FX : ONE_FX - pw;
         CRV_EXPO_INOUT: begin
            if (zero4_ff) eased_in = '0;
            else if (full4_ff) eased_in = ONE_FX;
            else if (lo4_ff) eased_in = pw;
            else eased_in = ONE_FX - pw;
         end
         CRV_HOLD:       eased_in = full4_ff ? ONE_FX : '0;
         default:        eased_in = t4_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         eased_ff <= eased_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, eased_ff};

endmodule
